// File: rtl/assert_macros.svh
// Assertion macros shared by the packed complex ALU RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: rtl/pca_pkg.sv
// Package with command codes and stage payload types of the packed complex ALU.
`timescale 1ns / 1ps

package pca_pkg;

	localparam int CmdWidth = 3;
	localparam int WordWidth = 64;

	localparam logic [CmdWidth-1:0] CMD_ADD  = 3'd0;
	localparam logic [CmdWidth-1:0] CMD_SUB  = 3'd1;
	localparam logic [CmdWidth-1:0] CMD_QMUL = 3'd2;
	localparam logic [CmdWidth-1:0] CMD_CONJ = 3'd3;
	localparam logic [CmdWidth-1:0] CMD_AVG  = 3'd4;
	localparam logic [CmdWidth-1:0] CMD_HSUB = 3'd5;

	localparam logic [33:0] Q15_ROUND = 34'h0_0000_8000;

	// Stage 1: Q15 products, exact 33-bit sums or differences, conjugate.
	typedef struct packed {
		logic [CmdWidth-1:0] cmd;
		logic signed [31:0]  prod_rr;
		logic signed [31:0]  prod_ii;
		logic signed [31:0]  prod_ir;
		logic signed [31:0]  prod_ri;
		logic signed [32:0]  t_re;
		logic signed [32:0]  t_im;
		logic [31:0]         conj_word;
	} s1_t;

	// Stage 2: every candidate result, selected in the last stage.
	typedef struct packed {
		logic [CmdWidth-1:0] cmd;
		logic [31:0]         wrap_re;
		logic [31:0]         wrap_im;
		logic [31:0]         mul_word;
		logic [31:0]         conj_word;
		logic [31:0]         avg_re;
		logic [31:0]         avg_im;
		logic [31:0]         half_re;
		logic [31:0]         half_im;
	} s2_t;

endpackage

// File: rtl/pca_front.sv
// First pipeline stage: Q15 partial products and 33-bit sums or differences.
`timescale 1ns / 1ps

module pca_front (
	input  logic                           clk,
	input  logic                           en,
	input  logic [pca_pkg::CmdWidth-1:0]   command,
	input  logic [pca_pkg::WordWidth-1:0]  operand_a,
	input  logic [pca_pkg::WordWidth-1:0]  operand_b,
	output pca_pkg::s1_t                   stage_s1
);
	import pca_pkg::*;

	logic signed [15:0] sr, si, tr, ti;
	logic signed [32:0] a_re, a_im, b_re, b_im;
	logic               sub_mode;
	logic [15:0]        conj_im;
	s1_t                next;

	assign sr = operand_a[15:0];
	assign si = operand_a[31:16];
	assign tr = operand_b[15:0];
	assign ti = operand_b[31:16];

	assign a_re = {operand_a[31], operand_a[31:0]};
	assign a_im = {operand_a[63], operand_a[63:32]};
	assign b_re = {operand_b[31], operand_b[31:0]};
	assign b_im = {operand_b[63], operand_b[63:32]};

	assign sub_mode = (command == CMD_SUB) || (command == CMD_HSUB);

	// Negating the most negative Q15 value saturates to the most positive one.
	assign conj_im = (operand_a[31:16] == 16'h8000) ? 16'h7fff : (16'h0000 - operand_a[31:16]);

	always_comb begin
		next.cmd       = command;
		next.prod_rr   = sr * tr;
		next.prod_ii   = si * ti;
		next.prod_ir   = si * tr;
		next.prod_ri   = ti * sr;
		next.t_re      = sub_mode ? (a_re - b_re) : (a_re + b_re);
		next.t_im      = sub_mode ? (a_im - b_im) : (a_im + b_im);
		next.conj_word = {conj_im, operand_a[15:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1 <= next;
		end
	end

endmodule

// File: rtl/pca_round.sv
// Second pipeline stage: Q15 rounding and saturation, halving with rounding.
`timescale 1ns / 1ps

module pca_round (
	input  logic         clk,
	input  logic         en,
	input  pca_pkg::s1_t stage_s1,
	output pca_pkg::s2_t stage_s2
);
	import pca_pkg::*;

	logic [33:0] q_re, q_im;
	logic [32:0] h_avg_re, h_avg_im, h_sub_re, h_sub_im;
	s2_t         next;

	// Takes the high half of a 32-bit saturated value given as 34 bits.
	function automatic logic [15:0] q15_high(input logic [33:0] s);
		logic fits;
		fits = (s[33:31] == 3'b000) || (s[33:31] == 3'b111);
		if (fits) begin
			return s[31:16];
		end
		return s[33] ? 16'h8000 : 16'h7fff;
	endfunction

	// Adds bit 1 and shifts right arithmetically by one.
	function automatic logic [32:0] round_half(input logic [32:0] t);
		logic [33:0] u;
		u = {t[32], t} + {33'b0, t[1]};
		return u[33:1];
	endfunction

	function automatic logic [31:0] sat32(input logic [32:0] h);
		if (h[32] == h[31]) begin
			return h[31:0];
		end
		return h[32] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

	assign q_re = {stage_s1.prod_rr[31], stage_s1.prod_rr, 1'b0}
		- {stage_s1.prod_ii[31], stage_s1.prod_ii, 1'b0} + Q15_ROUND;
	assign q_im = {stage_s1.prod_ir[31], stage_s1.prod_ir, 1'b0}
		+ {stage_s1.prod_ri[31], stage_s1.prod_ri, 1'b0} + Q15_ROUND;

	assign h_avg_re = round_half(stage_s1.t_re);
	assign h_avg_im = round_half(stage_s1.t_im);
	assign h_sub_re = h_avg_re;
	assign h_sub_im = h_avg_im;

	always_comb begin
		next.cmd       = stage_s1.cmd;
		next.wrap_re   = stage_s1.t_re[31:0];
		next.wrap_im   = stage_s1.t_im[31:0];
		next.mul_word  = {q15_high(q_im), q15_high(q_re)};
		next.conj_word = stage_s1.conj_word;
		next.avg_re    = h_avg_re[31:0];
		next.avg_im    = h_avg_im[31:0];
		next.half_re   = sat32(h_sub_re);
		next.half_im   = sat32(h_sub_im);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2 <= next;
		end
	end

endmodule

// File: rtl/packed_complex_alu.sv
// Top level of the packed complex ALU: handshake control and result select.
// Products, rounding and the result select take one stage each, registered in that order.
// Throughput: one word per cycle while res_stall does not hold a result word.
// The whole pipeline holds while a result word waits under res_stall.
// Reset clears only the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packed_complex_alu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic [pca_pkg::CmdWidth-1:0]   command,
	input  logic [pca_pkg::WordWidth-1:0]  operand_a,
	input  logic [pca_pkg::WordWidth-1:0]  operand_b,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [pca_pkg::WordWidth-1:0]  result_word
);
	import pca_pkg::*;

	logic                 adv;
	logic                 valid_s1, valid_s2, valid_s3;
	s1_t                  stage_s1;
	s2_t                  stage_s2;
	logic [CmdWidth-1:0]  cmd_s3;
	logic [WordWidth-1:0] word_s3;
	logic [WordWidth-1:0] sel_word;

	// All stages move together whenever the output word is not held.
	assign adv       = !(valid_s3 && res_stall);
	assign cmd_stall = !adv;

	pca_front u_front (
		.clk       (clk),
		.en        (adv),
		.command   (command),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.stage_s1  (stage_s1)
	);

	pca_round u_round (
		.clk      (clk),
		.en       (adv),
		.stage_s1 (stage_s1),
		.stage_s2 (stage_s2)
	);

	always_comb begin
		case (stage_s2.cmd)
			CMD_ADD, CMD_SUB: begin
				sel_word = {stage_s2.wrap_im, stage_s2.wrap_re};
			end
			CMD_QMUL: begin
				sel_word = {32'h0, stage_s2.mul_word};
			end
			CMD_CONJ: begin
				sel_word = {32'h0, stage_s2.conj_word};
			end
			CMD_AVG: begin
				sel_word = {stage_s2.avg_im, stage_s2.avg_re};
			end
			CMD_HSUB: begin
				sel_word = {stage_s2.half_im, stage_s2.half_re};
			end
			default: begin
				sel_word = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cmd_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3  <= stage_s2.cmd;
			word_s3 <= sel_word;
		end
	end

	assign res_valid   = valid_s3;
	assign result_word = word_s3;

	`ASSERT_NEXT(a_s2_reaches_output, clk, arst_n, valid_s2 && adv, res_valid)
	`ASSERT_IMPLIES(a_q15_upper_zero, clk, arst_n, res_valid && (cmd_s3 == CMD_QMUL || cmd_s3 == CMD_CONJ), result_word[63:32] == 32'h0)
	`ASSERT_IMPLIES(a_unused_cmd_zero, clk, arst_n, res_valid && cmd_s3 > CMD_HSUB, result_word == '0)

endmodule
